### hw/rtl/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// Used by dsu_ctrl, dsu_datapath and the top level; no dependencies.
package dsu_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int RANK_W    = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    // Request kinds
    localparam logic [1:0] KIND_MERGE = 2'd0;
    localparam logic [1:0] KIND_SAME  = 2'd1;
    localparam logic [1:0] KIND_SIZE  = 2'd2;
    localparam logic [1:0] KIND_FIND  = 2'd3;

    // Datapath commands, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LATCH,
        DP_BAD,
        DP_SRC_A,
        DP_FIND_RD,
        DP_FIND_STEP,
        DP_ROOT_SET,
        DP_COMP_RD,
        DP_COMP_WR,
        DP_SRC_B,
        DP_SAVE_X,
        DP_RD_X,
        DP_RD_Y,
        DP_FINISH
    } t_dp_op;

    // Datapath status back to the controller
    typedef struct packed {
        logic clr_last;
        logic bad;
        logic uses_b;
        logic link_self;
        logic at_root;
    } t_dp_stat;

endpackage

### hw/rtl/dsu_datapath.sv
// Datapath: parent, rank and size tables, walk registers and result registers.
// Depends on dsu_pkg; driven by commands from dsu_ctrl.
module dsu_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dsu_pkg::t_dp_op            i_op,
    output dsu_pkg::t_dp_stat          o_stat,
    input  logic                       i_cfg_we,
    input  logic [dsu_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_kind,
    input  logic [dsu_pkg::IDX_W-1:0]  i_elem_a,
    input  logic [dsu_pkg::IDX_W-1:0]  i_elem_b,
    output logic                       o_done,
    output logic [dsu_pkg::IDX_W-1:0]  o_root_a,
    output logic                       o_same_set,
    output logic [dsu_pkg::CNT_W-1:0]  o_set_size,
    output logic                       o_merged,
    output logic [dsu_pkg::CNT_W-1:0]  o_group_total,
    output logic                       o_bad_index
);

    logic [dsu_pkg::IDX_W-1:0]  mem_parent [dsu_pkg::MAX_ELEMS];
    logic [dsu_pkg::RANK_W-1:0] mem_rank   [dsu_pkg::MAX_ELEMS];
    logic [dsu_pkg::CNT_W-1:0]  mem_size   [dsu_pkg::MAX_ELEMS];

    logic [dsu_pkg::IDX_W-1:0]  r_clr;
    logic [dsu_pkg::CNT_W-1:0]  r_ecount;
    logic [dsu_pkg::CNT_W-1:0]  r_cnt;
    logic [1:0]                 r_kind;
    logic [dsu_pkg::IDX_W-1:0]  r_a, r_b, r_cur, r_org, r_root, r_root_x;
    logic [dsu_pkg::IDX_W-1:0]  r_p_rd;
    logic [dsu_pkg::RANK_W-1:0] r_rank_rd, r_rank_x;
    logic [dsu_pkg::CNT_W-1:0]  r_size_rd, r_size_x;
    logic                       r_done;
    logic [dsu_pkg::IDX_W-1:0]  r_root_a;
    logic                       r_same_set, r_merged, r_bad_index;
    logic [dsu_pkg::CNT_W-1:0]  r_set_size, r_group_total;

    logic [dsu_pkg::CNT_W-1:0]  active_n, n_cnt, groups;
    logic                       uses_b, do_merge, keep_y, rank_up;
    logic [dsu_pkg::IDX_W-1:0]  keep, lose, ts_addr;
    logic [dsu_pkg::CNT_W-1:0]  size_sum;

    // Clamp the element count to the table, with zero taken as one
    always_comb begin
        priority if (r_ecount == '0) begin
            active_n = dsu_pkg::CNT_W'(1);
        end else if (r_ecount > dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMS)) begin
            active_n = dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMS);
        end else begin
            active_n = r_ecount;
        end
    end

    // Merge decision from the two roots and their rank and size
    always_comb begin
        uses_b   = (r_kind == dsu_pkg::KIND_MERGE) || (r_kind == dsu_pkg::KIND_SAME);
        // Only a finishing merge counts; stale roots must not touch a bad-index result
        do_merge = (i_op == dsu_pkg::DP_FINISH) && (r_kind == dsu_pkg::KIND_MERGE)
                   && (r_root_x != r_root);
        keep_y   = r_rank_x < r_rank_rd;
        keep     = keep_y ? r_root : r_root_x;
        lose     = keep_y ? r_root_x : r_root;
        rank_up  = !keep_y && (r_rank_x == r_rank_rd) && (r_rank_x < dsu_pkg::RANK_MAX);
        size_sum = r_size_x + r_size_rd;
        n_cnt    = r_cnt + dsu_pkg::CNT_W'(do_merge);
        groups   = (n_cnt >= active_n) ? dsu_pkg::CNT_W'(1) : active_n - n_cnt;
        ts_addr  = (i_op == dsu_pkg::DP_RD_X) ? r_root_x : r_root;
    end

    always_comb begin
        o_stat.clr_last  = r_clr == dsu_pkg::IDX_W'(dsu_pkg::MAX_ELEMS - 1);
        o_stat.bad       = ({1'b0, r_a} >= active_n) || (uses_b && ({1'b0, r_b} >= active_n));
        o_stat.uses_b    = uses_b;
        o_stat.link_self = r_p_rd == r_cur;
        o_stat.at_root   = r_cur == r_root;
    end

    // Parent table: clear, path rewrite, merge link
    always_ff @(posedge i_clk) begin
        r_p_rd <= mem_parent[r_cur];
        if (i_op == dsu_pkg::DP_CLEAR) begin
            mem_parent[r_clr] <= r_clr;
        end else if (i_op == dsu_pkg::DP_COMP_WR) begin
            mem_parent[r_cur] <= r_root;
        end else if (i_op == dsu_pkg::DP_FINISH && do_merge) begin
            mem_parent[lose] <= keep;
        end
    end

    // Rank and size tables
    always_ff @(posedge i_clk) begin
        r_rank_rd <= mem_rank[ts_addr];
        r_size_rd <= mem_size[ts_addr];
        if (i_op == dsu_pkg::DP_CLEAR) begin
            mem_rank[r_clr] <= '0;
            mem_size[r_clr] <= dsu_pkg::CNT_W'(1);
        end else if (i_op == dsu_pkg::DP_FINISH && do_merge) begin
            mem_size[keep] <= size_sum;
            if (rank_up) begin
                mem_rank[r_root_x] <= r_rank_x + dsu_pkg::RANK_W'(1);
            end
        end
    end

    // Control registers: clear sweep, count register, merge count, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ecount <= dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMS);
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else begin
            if (i_op == dsu_pkg::DP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_ecount <= i_cfg_data;
            end
            if (i_op == dsu_pkg::DP_FINISH) begin
                r_cnt <= n_cnt;
            end
            r_done <= (i_op == dsu_pkg::DP_FINISH) || (i_op == dsu_pkg::DP_BAD);
        end
    end

    // Walk registers and results
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            dsu_pkg::DP_LATCH: begin
                r_kind <= i_kind;
                r_a    <= i_elem_a;
                r_b    <= i_elem_b;
            end
            dsu_pkg::DP_SRC_A: begin
                r_cur <= r_a;
                r_org <= r_a;
            end
            dsu_pkg::DP_SRC_B: begin
                r_root_x <= r_root;
                r_cur    <= r_b;
                r_org    <= r_b;
            end
            dsu_pkg::DP_SAVE_X: begin
                r_root_x <= r_root;
            end
            dsu_pkg::DP_FIND_STEP, dsu_pkg::DP_COMP_WR: begin
                r_cur <= r_p_rd;
            end
            dsu_pkg::DP_ROOT_SET: begin
                r_root <= r_cur;
                r_cur  <= r_org;
            end
            dsu_pkg::DP_RD_Y: begin
                r_rank_x <= r_rank_rd;
                r_size_x <= r_size_rd;
            end
            dsu_pkg::DP_BAD: begin
                r_root_a      <= '0;
                r_same_set    <= 1'b0;
                r_set_size    <= '0;
                r_merged      <= 1'b0;
                r_group_total <= groups;
                r_bad_index   <= 1'b1;
            end
            dsu_pkg::DP_FINISH: begin
                r_root_a      <= do_merge ? keep : r_root_x;
                r_same_set    <= (r_kind == dsu_pkg::KIND_MERGE) ||
                                 ((r_kind == dsu_pkg::KIND_SAME) && (r_root_x == r_root));
                r_set_size    <= do_merge ? size_sum : r_size_x;
                r_merged      <= do_merge;
                r_group_total <= groups;
                r_bad_index   <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_done        = r_done;
    assign o_root_a      = r_root_a;
    assign o_same_set    = r_same_set;
    assign o_set_size    = r_set_size;
    assign o_merged      = r_merged;
    assign o_group_total = r_group_total;
    assign o_bad_index   = r_bad_index;

endmodule

### hw/rtl/dsu_ctrl.sv
// Controller: sequences clearing, root search, path rewrite and merge.
// Depends on dsu_pkg; commands dsu_datapath.
module dsu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output dsu_pkg::t_dp_op    o_op,
    input  dsu_pkg::t_dp_stat  i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_FRD, S_FCHK, S_CRD, S_CWR, S_RDX, S_RDY, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_phase_b;

    // Pick command and next state
    always_comb begin
        o_op    = dsu_pkg::DP_NOP;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_op = dsu_pkg::DP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_op    = dsu_pkg::DP_LATCH;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    o_op    = dsu_pkg::DP_BAD;
                    n_state = S_IDLE;
                end else begin
                    o_op    = dsu_pkg::DP_SRC_A;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                o_op    = dsu_pkg::DP_FIND_RD;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.link_self) begin
                    o_op    = dsu_pkg::DP_ROOT_SET;
                    n_state = S_CRD;
                end else begin
                    o_op    = dsu_pkg::DP_FIND_STEP;
                    n_state = S_FRD;
                end
            end
            S_CRD: begin
                priority if (!i_stat.at_root) begin
                    o_op    = dsu_pkg::DP_COMP_RD;
                    n_state = S_CWR;
                end else if (r_phase_b) begin
                    n_state = S_RDX;
                end else if (i_stat.uses_b) begin
                    o_op    = dsu_pkg::DP_SRC_B;
                    n_state = S_FRD;
                end else begin
                    o_op    = dsu_pkg::DP_SAVE_X;
                    n_state = S_RDX;
                end
            end
            S_CWR: begin
                o_op    = dsu_pkg::DP_COMP_WR;
                n_state = S_CRD;
            end
            S_RDX: begin
                o_op    = dsu_pkg::DP_RD_X;
                n_state = S_RDY;
            end
            S_RDY: begin
                o_op    = dsu_pkg::DP_RD_Y;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_op    = dsu_pkg::DP_FINISH;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, busy and search phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_busy    <= 1'b1;
            r_phase_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            if (r_state == S_CHECK) begin
                r_phase_b <= 1'b0;
            end else if (o_op == dsu_pkg::DP_SRC_B) begin
                r_phase_b <= 1'b1;
            end
        end
    end

    assign busy = r_busy;

endmodule

### hw/rtl/disjoint_set_union_engine.sv
// Disjoint-set union engine: union by rank with full path compression over
// MAX_ELEMS elements. After reset the tables are swept clear, one entry a
// cycle, with busy high (count writes are taken meanwhile). A request is
// taken when start is high and busy low; its result appears on the o_ ports
// for one cycle with o_done high and cannot be held off. A taken request keeps
// busy high while the indices are checked, then for each element it names while
// the links to its root are walked (a read and a step each) and rewritten to
// the root (a read and a write each), then while the roots' ranks and sizes are
// read and the result finished; a bad index ends it at the check. The result
// shows in the first cycle with busy low.
// Depends on dsu_pkg, dsu_ctrl and dsu_datapath.
module disjoint_set_union_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [dsu_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_kind,
    input  logic [dsu_pkg::IDX_W-1:0]  i_elem_a,
    input  logic [dsu_pkg::IDX_W-1:0]  i_elem_b,
    output logic                       o_done,
    output logic [dsu_pkg::IDX_W-1:0]  o_root_a,
    output logic                       o_same_set,
    output logic [dsu_pkg::CNT_W-1:0]  o_set_size,
    output logic                       o_merged,
    output logic [dsu_pkg::CNT_W-1:0]  o_group_total,
    output logic                       o_bad_index
);

    dsu_pkg::t_dp_op   op;
    dsu_pkg::t_dp_stat stat;

    dsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_op    (op),
        .i_stat  (stat)
    );

    dsu_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_elem_a      (i_elem_a),
        .i_elem_b      (i_elem_b),
        .o_done        (o_done),
        .o_root_a      (o_root_a),
        .o_same_set    (o_same_set),
        .o_set_size    (o_set_size),
        .o_merged      (o_merged),
        .o_group_total (o_group_total),
        .o_bad_index   (o_bad_index)
    );

endmodule

### hw/rtl/dsu_checker.sv
// Port-level checks for the disjoint-set union engine, bound to the top.
// Depends on dsu_pkg and disjoint_set_union_engine.
module dsu_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [dsu_pkg::IDX_W-1:0]  o_root_a,
    input logic                       o_same_set,
    input logic [dsu_pkg::CNT_W-1:0]  o_set_size,
    input logic                       o_merged,
    input logic                       o_bad_index
);

    // Take a request, then stay busy with no result in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("request accepted without going busy");

    // Deliver a result only as the block frees up
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // Drop everything on a bad index
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_index) |->
            (o_root_a == '0 && o_set_size == '0 && !o_merged && !o_same_set))
        else $error("bad index result carries data");

    // A merge leaves both elements in one set of at least two
    a_merge_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_merged) |-> (o_same_set && o_set_size >= dsu_pkg::CNT_W'(2)))
        else $error("merge result inconsistent");

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_root_a    (o_root_a),
    .o_same_set  (o_same_set),
    .o_set_size  (o_set_size),
    .o_merged    (o_merged),
    .o_bad_index (o_bad_index)
);
